@@ hdl/fdtk_pkg.sv @@
// shared types and constants for the factor dot-product top-k recommender
// used by fdtk_mac, fdtk_cell and factor_dot_top_k_recommender
package fdtk_pkg;

  localparam int SCORE_W = 32;
  localparam int ACC_W   = 56;
  localparam int FAC_W   = 16;
  localparam int RANK_W  = 6;
  localparam int CNT_W   = 7;
  localparam int ADDR_W  = 4;

  // register indexes on the apb port (paddr[3:2])
  typedef enum logic [1:0] {
    REG_SCORE_MIN = 2'd0,
    REG_SCORE_MAX = 2'd1,
    REG_SVD_MODE  = 2'd2,
    REG_TOP_COUNT = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_e;

  // scoring configuration handed to the mac pipeline
  typedef struct packed {
    logic [SCORE_W-1:0] score_min;
    logic [SCORE_W-1:0] score_max;
    logic               svd;
  } score_cfg_t;

  // insert request leaving the mac pipeline
  typedef struct packed {
    logic ins;
    logic last;
  } ins_req_t;

  // command broadcast to every list cell
  typedef struct packed {
    logic ins;
    logic shl;
    logic clr;
  } cell_cmd_t;

endpackage

@@ hdl/fdtk_mac.sv @@
// multiply-accumulate pipeline: factor product, weighting, accumulation, clamp
// depends on fdtk_pkg
module fdtk_mac import fdtk_pkg::*; #(
  parameter int ITEM_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [ITEM_BITS-1:0]      item_i,
  input  logic                      rated_i,
  input  logic signed [FAC_W-1:0]   user_f_i,
  input  logic signed [FAC_W-1:0]   item_f_i,
  input  logic [FAC_W-1:0]          weight_i,
  input  logic                      last_f_i,
  input  logic                      last_i_i,
  input  score_cfg_t                cfg_i,
  output ins_req_t                  ins_o,
  output logic [SCORE_W-1:0]        ins_score_o,
  output logic [ITEM_BITS-1:0]      ins_item_o
);

  // stage 1: factor product
  logic                       p1_v_q, p1_rated_q, p1_lf_q, p1_li_q;
  logic signed [2*FAC_W-1:0]  p1_prod_q;
  logic [FAC_W-1:0]           p1_w_q;
  logic [ITEM_BITS-1:0]       p1_item_q;

  // stage 2: weighted term
  logic                       p2_v_q, p2_rated_q, p2_lf_q, p2_li_q;
  logic [ACC_W-1:0]           p2_term_q;
  logic [ITEM_BITS-1:0]       p2_item_q;

  // stage 3: accumulated sum of a finished item
  logic                       p3_ins_q, p3_li_q;
  logic [ACC_W-1:0]           p3_sum_q;
  logic [ITEM_BITS-1:0]       p3_item_q;

  // stage 4: clamped score
  logic                       p4_ins_q, p4_li_q;
  logic [SCORE_W-1:0]         p4_score_q;
  logic [ITEM_BITS-1:0]       p4_item_q;

  logic [ACC_W-1:0]           acc_q, acc_d, sum;
  logic signed [48:0]         wprod;
  logic [ACC_W-1:0]           term_d;
  logic signed [39:0]         q_raw, q_hi, lo_x, hi_x;
  logic [SCORE_W-1:0]         score_d;

  // weighting: q8.8 weight in svd mode, else scale by 2^8
  always_comb begin
    wprod = p1_prod_q * $signed({1'b0, p1_w_q});
    if (cfg_i.svd) begin
      term_d = {{(ACC_W-49){wprod[48]}}, wprod};
    end else begin
      term_d = {{(ACC_W-40){p1_prod_q[2*FAC_W-1]}}, p1_prod_q, 8'd0};
    end
  end

  // accumulation, wraps modulo 2^56
  always_comb begin
    sum   = acc_q + p2_term_q;
    acc_d = acc_q;
    if (p2_v_q) begin
      acc_d = (p2_lf_q || p2_li_q) ? '0 : sum;
    end
  end

  // floor shift to q16.16, clamp high then low
  always_comb begin
    q_raw   = $signed(p3_sum_q[ACC_W-1:16]);
    hi_x    = $signed({{8{cfg_i.score_max[SCORE_W-1]}}, cfg_i.score_max});
    lo_x    = $signed({{8{cfg_i.score_min[SCORE_W-1]}}, cfg_i.score_min});
    q_hi    = (q_raw > hi_x) ? hi_x : q_raw;
    score_d = (q_hi < lo_x) ? cfg_i.score_min : q_hi[SCORE_W-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q   <= 1'b0;
      p2_v_q   <= 1'b0;
      p3_ins_q <= 1'b0;
      p3_li_q  <= 1'b0;
      p4_ins_q <= 1'b0;
      p4_li_q  <= 1'b0;
      acc_q    <= '0;
    end else begin
      p1_v_q   <= in_valid_i;
      p2_v_q   <= p1_v_q;
      p3_ins_q <= p2_v_q && p2_lf_q && !p2_rated_q;
      p3_li_q  <= p2_v_q && p2_li_q;
      p4_ins_q <= p3_ins_q;
      p4_li_q  <= p3_li_q;
      acc_q    <= acc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p1_prod_q  <= user_f_i * item_f_i;
    p1_w_q     <= weight_i;
    p1_item_q  <= item_i;
    p1_rated_q <= rated_i;
    p1_lf_q    <= last_f_i;
    p1_li_q    <= last_i_i;
    p2_term_q  <= term_d;
    p2_item_q  <= p1_item_q;
    p2_rated_q <= p1_rated_q;
    p2_lf_q    <= p1_lf_q;
    p2_li_q    <= p1_li_q;
    p3_sum_q   <= sum;
    p3_item_q  <= p2_item_q;
    p4_score_q <= score_d;
    p4_item_q  <= p3_item_q;
  end

  assign ins_o.ins   = p4_ins_q;
  assign ins_o.last  = p4_li_q;
  assign ins_score_o = p4_score_q;
  assign ins_item_o  = p4_item_q;

endmodule

@@ hdl/fdtk_cell.sv @@
// one slot of the descending top list; inserts, shifts down on insert,
// shifts up toward slot 0 while the list is read out; depends on fdtk_pkg
module fdtk_cell import fdtk_pkg::*; #(
  parameter int ITEM_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_cmd_t            cmd_i,
  input  logic [SCORE_W-1:0]   new_score_i,
  input  logic [ITEM_BITS-1:0] new_item_i,
  input  logic                 gt_prev_i,
  input  logic                 prev_present_i,
  input  logic [SCORE_W-1:0]   prev_score_i,
  input  logic [ITEM_BITS-1:0] prev_item_i,
  input  logic                 next_present_i,
  input  logic [SCORE_W-1:0]   next_score_i,
  input  logic [ITEM_BITS-1:0] next_item_i,
  output logic                 gt_o,
  output logic                 present_o,
  output logic [SCORE_W-1:0]   score_o,
  output logic [ITEM_BITS-1:0] item_o
);

  logic                 present_q, present_d;
  logic [SCORE_W-1:0]   score_q, score_d;
  logic [ITEM_BITS-1:0] item_q, item_d;
  logic                 take_new, take_prev;

  // new item beats this slot when the slot is empty or strictly lower
  assign gt_o      = !present_q || ($signed(new_score_i) > $signed(score_q));
  assign take_new  = cmd_i.ins && gt_o && !gt_prev_i;
  assign take_prev = cmd_i.ins && gt_prev_i;

  always_comb begin
    present_d = present_q;
    score_d   = score_q;
    item_d    = item_q;
    if (cmd_i.clr) begin
      present_d = 1'b0;
    end else if (cmd_i.shl) begin
      present_d = next_present_i;
      score_d   = next_score_i;
      item_d    = next_item_i;
    end else if (take_prev) begin
      present_d = prev_present_i;
      score_d   = prev_score_i;
      item_d    = prev_item_i;
    end else if (take_new) begin
      present_d = 1'b1;
      score_d   = new_score_i;
      item_d    = new_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
    end else begin
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    item_q  <= item_d;
  end

  assign present_o = present_q;
  assign score_o   = score_q;
  assign item_o    = item_q;

endmodule

@@ hdl/factor_dot_top_k_recommender.sv @@
// top level: apb registers, mac pipeline, chain of top-k list cells, readout
// depends on fdtk_pkg, fdtk_mac, fdtk_cell
//
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | one factor pair, tlast = last item of user
// m_*      | out | m_tvalid/m_tready  | one ranked result, tlast = final rank
// apb      | in  | psel/penable       | four config registers at 4*i
//
// during a user's run one transfer is taken per cycle; a finished item
// passes the product, weight, accumulate and clamp stages into the cell
// chain, where all cells compare and shift together. after the last item,
// s_tready stays low during the drain and while the top_count results,
// clamped to 1 .. MAX_TOP, leave from slot 0, one per m_tready cycle, as
// the chain shifts up. reset empties the list at once; no clearing pass.
module factor_dot_top_k_recommender import fdtk_pkg::*; #(
  parameter int MAX_TOP   = 64,
  parameter int ITEM_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [63:0]        s_tdata,   // item_index, user_factor, item_factor, singular_weight
  input  logic [1:0]         s_tuser,   // already_rated, last_factor
  input  logic               s_tlast,   // last_item
  // result stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [55:0]        m_tdata,   // rank, chosen_item, score, zero pad
  output logic               m_tuser,   // item_present
  output logic               m_tlast,   // last_rank
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [CNT_W-1:0] MaxTopC = CNT_W'(MAX_TOP);

  // configuration registers
  logic [SCORE_W-1:0] score_min_q, score_max_q;
  logic               svd_mode_q;
  logic [CNT_W-1:0]   top_count_q;
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  ctrl_state_e        state_q, state_d;
  logic [RANK_W-1:0]  cnt_q;
  logic [RANK_W-1:0]  last_idx;
  logic [CNT_W-1:0]   n_eff;

  logic               in_xfer, out_xfer;
  score_cfg_t         score_cfg;
  ins_req_t           ins_req;
  logic [SCORE_W-1:0] ins_score;
  logic [ITEM_BITS-1:0] ins_item;
  cell_cmd_t          cmd;

  logic                 gt      [MAX_TOP];
  logic                 c_pres  [MAX_TOP];
  logic [SCORE_W-1:0]   c_score [MAX_TOP];
  logic [ITEM_BITS-1:0] c_item  [MAX_TOP];
  logic [MAX_TOP-1:0]   pres_vec;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_min_q <= '0;
      score_max_q <= 32'd327680;
      svd_mode_q  <= 1'b0;
      top_count_q <= CNT_W'(10);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SCORE_MIN: score_min_q <= pwdata;
        REG_SCORE_MAX: score_max_q <= pwdata;
        REG_SVD_MODE:  svd_mode_q  <= pwdata[0];
        REG_TOP_COUNT: top_count_q <= pwdata[CNT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCORE_MIN: prdata = score_min_q;
      REG_SCORE_MAX: prdata = score_max_q;
      REG_SVD_MODE:  prdata = {31'd0, svd_mode_q};
      REG_TOP_COUNT: prdata = {{(32-CNT_W){1'b0}}, top_count_q};
      default:       prdata = '0;
    endcase
  end

  // handshakes
  assign s_tready = (state_q == ST_RUN);
  assign in_xfer  = s_tvalid && s_tready;
  assign m_tvalid = (state_q == ST_EMIT);
  assign out_xfer = m_tvalid && m_tready;

  assign score_cfg.score_min = score_min_q;
  assign score_cfg.score_max = score_max_q;
  assign score_cfg.svd       = svd_mode_q;

  fdtk_mac #(
    .ITEM_BITS(ITEM_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_xfer),
    .item_i      (ITEM_BITS'(s_tdata[15:0])),
    .rated_i     (s_tuser[0]),
    .user_f_i    ($signed(s_tdata[31:16])),
    .item_f_i    ($signed(s_tdata[47:32])),
    .weight_i    (s_tdata[63:48]),
    .last_f_i    (s_tuser[1]),
    .last_i_i    (s_tlast),
    .cfg_i       (score_cfg),
    .ins_o       (ins_req),
    .ins_score_o (ins_score),
    .ins_item_o  (ins_item)
  );

  // results per user, clamped to 1 .. MAX_TOP
  always_comb begin
    if (top_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (top_count_q > MaxTopC) begin
      n_eff = MaxTopC;
    end else begin
      n_eff = top_count_q;
    end
    last_idx = RANK_W'(n_eff - CNT_W'(1));
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN:   if (in_xfer && s_tlast) state_d = ST_DRAIN;
      ST_DRAIN: if (ins_req.last) state_d = ST_EMIT;
      ST_EMIT:  if (out_xfer && (cnt_q == last_idx)) state_d = ST_RUN;
      default:  state_d = ST_RUN;
    endcase
  end

  // rank counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q != ST_EMIT) begin
      cnt_q <= '0;
    end else if (out_xfer) begin
      cnt_q <= cnt_q + RANK_W'(1);
    end
  end

  // cell commands
  assign cmd.ins = ins_req.ins;
  assign cmd.shl = out_xfer && (cnt_q != last_idx);
  assign cmd.clr = out_xfer && (cnt_q == last_idx);

  // chain of list cells, slot 0 best
  for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
    logic                 gt_prev, prev_pres, next_pres;
    logic [SCORE_W-1:0]   prev_score, next_score;
    logic [ITEM_BITS-1:0] prev_item, next_item;

    if (i == 0) begin : g_head
      assign gt_prev    = 1'b0;
      assign prev_pres  = 1'b0;
      assign prev_score = '0;
      assign prev_item  = '0;
    end else begin : g_body
      assign gt_prev    = gt[i-1];
      assign prev_pres  = c_pres[i-1];
      assign prev_score = c_score[i-1];
      assign prev_item  = c_item[i-1];
    end

    if (i == MAX_TOP - 1) begin : g_tail
      assign next_pres  = 1'b0;
      assign next_score = '0;
      assign next_item  = '0;
    end else begin : g_inner
      assign next_pres  = c_pres[i+1];
      assign next_score = c_score[i+1];
      assign next_item  = c_item[i+1];
    end

    fdtk_cell #(
      .ITEM_BITS(ITEM_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .new_score_i    (ins_score),
      .new_item_i     (ins_item),
      .gt_prev_i      (gt_prev),
      .prev_present_i (prev_pres),
      .prev_score_i   (prev_score),
      .prev_item_i    (prev_item),
      .next_present_i (next_pres),
      .next_score_i   (next_score),
      .next_item_i    (next_item),
      .gt_o           (gt[i]),
      .present_o      (c_pres[i]),
      .score_o        (c_score[i]),
      .item_o         (c_item[i])
    );

    assign pres_vec[i] = c_pres[i];
  end

  // result from slot 0
  always_comb begin
    m_tdata        = '0;
    m_tdata[5:0]   = cnt_q;
    m_tdata[21:6]  = c_pres[0] ? 16'(c_item[0]) : 16'd0;
    m_tdata[53:22] = c_pres[0] ? c_score[0] : '0;
  end
  assign m_tuser = c_pres[0];
  assign m_tlast = (cnt_q == last_idx);

  // filled slots always form a prefix of the list
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pres_vec + MAX_TOP'(1)) & pres_vec) == '0)
    else $error("list holds a gap");

  // no insert lands while results are leaving
  a_no_ins_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> !ins_req.ins)
    else $error("insert during readout");

  // the list is empty after the final rank leaves
  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && m_tlast) |=> (pres_vec == '0))
    else $error("list not cleared after readout");

  // the rank counter never passes the final rank
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (cnt_q <= last_idx))
    else $error("rank beyond list length");

endmodule
